// ===== rtl/smpq_pkg.sv =====
// Shared types and codes for the sorted max-priority queue.
// Used by smpq_mem, smpq_ctrl and sorted_max_priority_queue; depends on nothing.
package smpq_pkg;

  // Command carried in s_axis_tuser
  typedef enum logic {
    CMD_ENQ = 1'b0,
    CMD_DEQ = 1'b1
  } cmd_t;

  // Result status carried in m_axis_tuser
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // One queue entry as held in the memory
  typedef struct packed {
    logic signed [31:0] pri;
    logic signed [31:0] data;
  } entry_t;

  // One result beat
  typedef struct packed {
    status_t            status;
    logic signed [31:0] out_data;
    logic signed [31:0] out_priority;
    logic [4:0]         occupancy;
  } result_t;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_DEQ_OUT,
    S_WALK,
    S_DONE
  } state_t;

endpackage

// ===== rtl/sorted_max_priority_queue.sv =====
// Sorted max-priority queue: top level with output register and checks.
// Depends on smpq_pkg, smpq_mem and smpq_ctrl.
//
// Max-priority queue of DEPTH entries kept sorted in a circular buffer in one
// RAM. Each input beat is an enqueue or a dequeue and yields one result beat.
// An enqueue lands behind every entry of greater or equal priority, so ties
// leave in arrival order; on a full queue it is refused with status full. A
// dequeue returns the highest-priority entry or status empty. The block takes
// one beat at a time. An accepted enqueue walks back past every held entry of
// lower priority, moving one entry per cycle through the single write port and
// the single read port of the entry RAM. A result may wait in the output
// register while the next beat is accepted.
module sorted_max_priority_queue
  import smpq_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,  // [31:0] data_value, [63:32] priority_value
  input  logic [0:0]  s_axis_tuser,  // [0] command
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,  // [31:0] out_data, [63:32] out_priority,
                                     // [68:64] occupancy, [71:69] zero
  output logic [1:0]  m_axis_tuser   // [1:0] status
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  entry_t        in_entry;
  cmd_t          in_cmd;
  logic          res_valid;
  logic          res_take;
  result_t       res;
  result_t       out_res;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [AW-1:0] mem_raddr;
  entry_t        mem_wdata;
  entry_t        mem_rdata;

  // unpack the input beat
  assign in_entry = '{pri: s_axis_tdata[63:32], data: s_axis_tdata[31:0]};
  assign in_cmd   = cmd_t'(s_axis_tuser[0]);

  smpq_ctrl #(
    .DEPTH(DEPTH),
    .AW   (AW),
    .CW   (CW)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_cmd   (in_cmd),
    .in_entry (in_entry),
    .res_valid(res_valid),
    .res_take (res_take),
    .res      (res),
    .mem_we   (mem_we),
    .mem_waddr(mem_waddr),
    .mem_wdata(mem_wdata),
    .mem_raddr(mem_raddr),
    .mem_rdata(mem_rdata)
  );

  smpq_mem #(
    .DEPTH(DEPTH),
    .AW   (AW)
  ) u_mem (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  // output register: loads when empty or being drained
  assign res_take = res_valid && (!m_axis_tvalid || m_axis_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (res_take) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) out_res <= res;
  end

  assign m_axis_tdata = {3'b000, out_res.occupancy, out_res.out_priority,
                         out_res.out_data};
  assign m_axis_tuser = out_res.status;

  // checks
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("sequencer took a beat while busy");

  a_refused_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (out_res.status != ST_OK) |->
      (out_res.out_data == '0) && (out_res.out_priority == '0))
    else $error("refused beat carries entry data");

  a_empty_occ: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (out_res.status == ST_EMPTY) |-> (out_res.occupancy == '0))
    else $error("empty status with nonzero occupancy");

  a_take_only_done: assert property (@(posedge clk) disable iff (rst)
    res_take |=> !res_valid)
    else $error("result handed over twice");

endmodule

// ===== rtl/smpq_mem.sv =====
// Entry store: one write port and one read port with registered read data.
// Depends on smpq_pkg for entry_t.
module smpq_mem
  import smpq_pkg::*;
#(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  entry_t        wdata,
  input  logic [AW-1:0] raddr,
  output entry_t        rdata
);

  entry_t mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/smpq_ctrl.sv =====
// Sequencer: circular buffer pointers, insertion walk with one shared compare,
// dequeue from the head. Depends on smpq_pkg and drives smpq_mem.
module smpq_ctrl
  import smpq_pkg::*;
#(
  parameter int DEPTH = 16,
  parameter int AW    = 4,
  parameter int CW    = 5
) (
  input  logic          clk,
  input  logic          rst,
  // input beat
  input  logic          in_valid,
  output logic          in_ready,
  input  cmd_t          in_cmd,
  input  entry_t        in_entry,
  // result handoff to the output register
  output logic          res_valid,
  input  logic          res_take,
  output result_t       res,
  // memory ports
  output logic          mem_we,
  output logic [AW-1:0] mem_waddr,
  output entry_t        mem_wdata,
  output logic [AW-1:0] mem_raddr,
  input  entry_t        mem_rdata
);

  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  state_t        state, state_next;
  cmd_t          cmd;
  entry_t        item;
  logic [AW-1:0] head, head_next;
  logic [AW-1:0] tail, tail_next;
  logic [CW-1:0] count, count_next;
  logic [AW-1:0] wp, wp_next;      // slot being filled during the walk
  logic [CW-1:0] left, left_next;  // entries still ahead of the walk
  result_t       res_next;
  logic          move_back;

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] x);
    ptr_inc = (x == LAST_IDX) ? '0 : x + 1'b1;
  endfunction

  function automatic logic [AW-1:0] ptr_dec(input logic [AW-1:0] x);
    ptr_dec = (x == '0) ? LAST_IDX : x - 1'b1;
  endfunction

  // shared compare: new entry outranks the one read
  assign move_back = (left != '0) && (item.pri > mem_rdata.pri);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_EXEC;
      end
      S_EXEC: begin
        if (cmd == CMD_DEQ) begin
          state_next = (count == '0) ? S_DONE : S_DEQ_OUT;
        end else begin
          state_next = (count == FULL_CNT) ? S_DONE : S_WALK;
        end
      end
      S_DEQ_OUT: state_next = S_DONE;
      S_WALK: begin
        if (!move_back) state_next = S_DONE;
      end
      S_DONE: begin
        if (res_take) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    head_next  = head;
    tail_next  = tail;
    count_next = count;
    wp_next    = wp;
    left_next  = left;
    res_next   = res;
    mem_we     = 1'b0;
    mem_waddr  = wp;
    mem_wdata  = item;
    mem_raddr  = ptr_dec(tail);
    in_ready   = (state == S_IDLE);
    res_valid  = (state == S_DONE);
    unique case (state)
      S_IDLE: ;
      S_EXEC: begin
        res_next = '{status: ST_OK, out_data: '0, out_priority: '0,
                     occupancy: 5'(count)};
        if (cmd == CMD_DEQ) begin
          mem_raddr = head;
          if (count == '0) res_next.status = ST_EMPTY;
        end else begin
          // read the back entry, start filling at the tail slot
          wp_next   = tail;
          left_next = count;
          if (count == FULL_CNT) res_next.status = ST_FULL;
        end
      end
      S_DEQ_OUT: begin
        head_next  = ptr_inc(head);
        count_next = count - 1'b1;
        res_next   = '{status: ST_OK, out_data: mem_rdata.data,
                       out_priority: mem_rdata.pri, occupancy: 5'(count - 1'b1)};
      end
      S_WALK: begin
        mem_we = 1'b1;
        if (move_back) begin
          // shift the lower-priority entry back, read the one before it
          mem_wdata = mem_rdata;
          wp_next   = ptr_dec(wp);
          left_next = left - 1'b1;
          mem_raddr = ptr_dec(ptr_dec(wp));
        end else begin
          tail_next  = ptr_inc(tail);
          count_next = count + 1'b1;
          res_next.occupancy = 5'(count + 1'b1);
        end
      end
      S_DONE: ;
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      state <= state_next;
      head  <= head_next;
      tail  <= tail_next;
      count <= count_next;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      cmd  <= in_cmd;
      item <= in_entry;
    end
    wp   <= wp_next;
    left <= left_next;
    res  <= res_next;
  end

endmodule
